### rtl/kct_pkg.sv
// Shared types and constants for the keyed count table.
`default_nettype none
package kct_pkg;

    localparam int REQ_W   = 3;
    localparam int KEY_W   = 16;
    localparam int COUNT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD      = 3'd0,
        REQ_REMOVE   = 3'd1,
        REQ_CONTAINS = 3'd2,
        REQ_GET      = 3'd3,
        REQ_CLEAR    = 3'd4
    } req_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;  // latch request, match keys, read count memory
        logic commit;   // update table, load result register
    } cmd_t;

endpackage
`default_nettype wire

### rtl/kct_ctrl.sv
// Sequencing state machine and result valid flag for the keyed count table.
`default_nettype none
module kct_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    output kct_pkg::cmd_t     cmd
);

    kct_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kct_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            kct_pkg::ST_IDLE: begin
                // no transaction is taken while reset is held
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = kct_pkg::ST_EXEC;
                end
            end
            kct_pkg::ST_EXEC: begin
                // result slot must be free (or draining this cycle)
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = kct_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kct_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_capture_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == kct_pkg::ST_EXEC))
        else $error("capture did not move to execute");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("commit overwrote an untaken result");
    a_valid_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.commit))
        else $error("result valid raised without commit");
`endif

endmodule
`default_nettype wire

### rtl/kct_datapath.sv
// Slot storage, key match, count memory and result register of the keyed count table.
`default_nettype none
module kct_datapath #(
    parameter int ENTRIES = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire kct_pkg::cmd_t               cmd,
    input  wire logic [kct_pkg::REQ_W-1:0]   s_req_type,
    input  wire logic [kct_pkg::KEY_W-1:0]   s_item_key,
    input  wire logic [kct_pkg::COUNT_W-1:0] s_amount,
    output logic                             m_found,
    output logic [kct_pkg::COUNT_W-1:0]      m_count_now,
    output logic                             m_enough,
    output logic                             m_table_full
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = kct_pkg::COUNT_W;

    // slot state
    logic [ENTRIES-1:0]          slot_valid_reg, slot_valid_next;
    logic [kct_pkg::KEY_W-1:0]   slot_key_reg [ENTRIES];
    logic [CW-1:0]               count_mem [ENTRIES];

    // captured request
    kct_pkg::req_t               req_reg;
    logic [kct_pkg::KEY_W-1:0]   key_reg;
    logic [CW-1:0]               amt_reg;
    logic                        hit_reg, free_reg;
    logic [IDX_W-1:0]            hit_idx_reg, free_idx_reg;
    logic [CW-1:0]               cnt_rd_reg;

    // result register
    logic                        out_found_reg, out_enough_reg, out_full_reg;
    logic [CW-1:0]               out_count_reg;

    // lookup
    logic                        hit_c, free_c;
    logic [IDX_W-1:0]            hit_idx_c, free_idx_c;

    // commit
    logic                        mem_we, key_we;
    logic [IDX_W-1:0]            mem_waddr;
    logic [CW-1:0]               mem_wdata;
    logic                        found_c, enough_c, full_c;
    logic [CW-1:0]               count_c;
    logic [CW:0]                 sum_c;

    // lowest matching and lowest free slot
    always_comb begin
        hit_c      = 1'b0;
        hit_idx_c  = '0;
        free_c     = 1'b0;
        free_idx_c = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (slot_valid_reg[i] && (slot_key_reg[i] == s_item_key)) begin
                hit_c     = 1'b1;
                hit_idx_c = IDX_W'(i);
            end
            if (!slot_valid_reg[i]) begin
                free_c     = 1'b1;
                free_idx_c = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg      <= kct_pkg::req_t'(s_req_type);
            key_reg      <= s_item_key;
            amt_reg      <= s_amount;
            hit_reg      <= hit_c;
            hit_idx_reg  <= hit_idx_c;
            free_reg     <= free_c;
            free_idx_reg <= free_idx_c;
            cnt_rd_reg   <= count_mem[hit_idx_c];
        end
        if (mem_we) begin
            count_mem[mem_waddr] <= mem_wdata;
        end
        if (key_we) begin
            slot_key_reg[free_idx_reg] <= key_reg;
        end
    end

    always_comb begin
        sum_c           = {1'b0, cnt_rd_reg} + {1'b0, amt_reg};
        slot_valid_next = slot_valid_reg;
        mem_we          = 1'b0;
        key_we          = 1'b0;
        mem_waddr       = hit_idx_reg;
        mem_wdata       = '0;
        found_c         = 1'b0;
        enough_c        = 1'b0;
        full_c          = 1'b0;
        count_c         = '0;
        unique case (req_reg)
            kct_pkg::REQ_ADD: begin
                found_c = hit_reg;
                if (hit_reg) begin
                    count_c   = sum_c[CW] ? kct_pkg::COUNT_MAX : sum_c[CW-1:0];
                    mem_we    = 1'b1;
                    mem_wdata = count_c;
                end else if (free_reg) begin
                    count_c                       = amt_reg;
                    mem_we                        = 1'b1;
                    key_we                        = 1'b1;
                    mem_waddr                     = free_idx_reg;
                    mem_wdata                     = amt_reg;
                    slot_valid_next[free_idx_reg] = 1'b1;
                end else begin
                    full_c = 1'b1;
                end
            end
            kct_pkg::REQ_REMOVE: begin
                found_c = hit_reg;
                if (hit_reg) begin
                    if (amt_reg >= cnt_rd_reg) begin
                        slot_valid_next[hit_idx_reg] = 1'b0;
                    end else begin
                        count_c   = cnt_rd_reg - amt_reg;
                        mem_we    = 1'b1;
                        mem_wdata = count_c;
                    end
                end
            end
            kct_pkg::REQ_CONTAINS: begin
                found_c  = hit_reg;
                count_c  = hit_reg ? cnt_rd_reg : '0;
                enough_c = hit_reg && (cnt_rd_reg >= amt_reg);
            end
            kct_pkg::REQ_GET: begin
                found_c = hit_reg;
                count_c = hit_reg ? cnt_rd_reg : '0;
            end
            kct_pkg::REQ_CLEAR: begin
                slot_valid_next = '0;
            end
            default: begin
            end
        endcase
        if (!cmd.commit) begin
            slot_valid_next = slot_valid_reg;
            mem_we          = 1'b0;
            key_we          = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
        end else begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_found_reg  <= found_c;
            out_count_reg  <= count_c;
            out_enough_reg <= enough_c;
            out_full_reg   <= full_c;
        end
    end

    assign m_found      = out_found_reg;
    assign m_count_now  = out_count_reg;
    assign m_enough     = out_enough_reg;
    assign m_table_full = out_full_reg;

`ifndef SYNTHESIS
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && (req_reg == kct_pkg::REQ_CLEAR) |=> (slot_valid_reg == '0))
        else $error("clear left a slot valid");
    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && (req_reg == kct_pkg::REQ_ADD) && !hit_reg && !free_reg
        |=> out_full_reg && $stable(slot_valid_reg))
        else $error("dropped add not flagged or changed table");
    a_full_only_add: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && (req_reg != kct_pkg::REQ_ADD) |=> !out_full_reg)
        else $error("table full flagged outside add");
`endif

endmodule
`default_nettype wire

### rtl/keyed_count_table.sv
// Top level of the keyed count table: controller plus datapath.
//
// Associative table of ENTRIES slots, each a 16-bit item key with a 16-bit
// count. One request transaction on the s_ channel (s_req_type, s_item_key,
// s_amount) gives exactly one result transaction on the m_ channel
// (m_found, m_count_now, m_enough, m_table_full). Both channels are
// valid/ready; a transaction moves when valid and ready are both high.
// Requests: add (saturating at 65535, takes lowest free slot for a new key,
// flags table_full if none), remove (frees the slot at zero or below),
// contains check, get count, clear all. Other codes give an all-zero result.
// The block takes a new request only in idle, after the previous one has
// committed. The count memory is read into a register in the capture cycle,
// followed by the read-modify-write and result load in the execute cycle.
// Key match over all slots happens combinationally in the capture cycle
// against flip-flop key storage.
// A new request is taken while a previous result still waits; if the
// receiver stalls, the block holds in execute until the result register is
// free, and s_ready stays low meanwhile.
// Reset (aresetn, synchronous, active low) empties the table at once via the
// slot valid bits and holds s_ready low; stored keys and counts are not reset.
`default_nettype none
module keyed_count_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [kct_pkg::REQ_W-1:0]   s_req_type,
    input  wire logic [kct_pkg::KEY_W-1:0]   s_item_key,
    input  wire logic [kct_pkg::COUNT_W-1:0] s_amount,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_found,
    output logic [kct_pkg::COUNT_W-1:0]      m_count_now,
    output logic                             m_enough,
    output logic                             m_table_full
);

    kct_pkg::cmd_t cmd;

    // sequencing: idle/capture, then execute, which commits once the result slot is free
    kct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // storage, match and arithmetic
    kct_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_req_type   (s_req_type),
        .s_item_key   (s_item_key),
        .s_amount     (s_amount),
        .m_found      (m_found),
        .m_count_now  (m_count_now),
        .m_enough     (m_enough),
        .m_table_full (m_table_full)
    );

endmodule
`default_nettype wire
